// ===== rtl/dynamic_loss_scale_update_core_macros.svh =====
// ----------------------------------------------------------------------------
// dynamic loss scale update core assertion macros
// concurrent checks sampled on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_LOSS_SCALE_UPDATE_CORE_MACROS_SVH
`define DYNAMIC_LOSS_SCALE_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define DLSU_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DLSU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/dlsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsu_pkg
// shared widths, constants and types of the dynamic loss scale updater
// ----------------------------------------------------------------------------
package dlsu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int SCALE_W   = 40;
  localparam int CNT_W     = 16;
  localparam int FACT_W    = 8;
  localparam int GRAD_W    = 32;
  localparam int PROD_W    = SCALE_W + FACT_W;
  localparam int EXP_LSB   = 23;
  localparam int EXP_MSB   = 30;
  localparam int IDX_W     = 2;

  // restoring divider runs one quotient bit per cycle
  localparam int DIV_STEPS = SCALE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SCALE_W-1:0] SCALE_ONE   = SCALE_W'(1) << FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536) << FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  localparam logic [FACT_W-1:0] BACKOFF_RESET  = FACT_W'(2);
  localparam logic [FACT_W-1:0] GROWTH_RESET   = FACT_W'(2);
  localparam logic [CNT_W-1:0]  INTERVAL_RESET = CNT_W'(2000);

  typedef enum logic [IDX_W-1:0] {
    CFG_START_SCALE = 2'd0,
    CFG_BACKOFF     = 2'd1,
    CFG_GROWTH      = 2'd2,
    CFG_INTERVAL    = 2'd3
  } cfg_idx_e;

  // one finished step waiting for its scale update
  typedef struct packed {
    logic ovf;
  } step_t;

  typedef struct packed {
    logic [FACT_W-1:0] backoff;
    logic [FACT_W-1:0] growth;
    logic [CNT_W-1:0]  interval;
  } cfg_t;

  typedef struct packed {
    logic               load;
    logic [SCALE_W-1:0] value;
  } scale_load_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SAT  = 5'b01000,
    S_DONE = 5'b10000
  } back_state_e;

  function automatic logic [SCALE_W-1:0] at_least_one(input logic [SCALE_W-1:0] v);
    return (v < SCALE_ONE) ? SCALE_ONE : v;
  endfunction

endpackage

// ===== rtl/dynamic_loss_scale_update_core.sv =====
// ----------------------------------------------------------------------------
// dynamic_loss_scale_update_core: one gradient word per cycle, one result per step
// words stall only while two finished steps wait in the queue; a result follows its
// last word through S_DIV (backoff, serial), S_MUL and S_SAT (growth), then S_DONE
// async active-low reset: scale 65536.0, count 0, flag 0, registers to defaults
// ----------------------------------------------------------------------------
`include "dynamic_loss_scale_update_core_macros.svh"

module dynamic_loss_scale_update_core
  import dlsu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [SCALE_W-1:0]   cfg_data_i,
  // gradient word stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [GRAD_W-1:0]    s_axis_tdata_i,   // [31:0] grad_bits
  input  logic                 s_axis_tlast_i,   // last
  // per-step result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [SCALE_W+CNT_W-1:0] m_axis_tdata_o, // [39:0] scale_after, [55:40] clean_steps
  output logic                 m_axis_tuser_o    // overflow
);

  // configuration registers; the start scale goes straight into the scale register
  cfg_t        cfg_q, cfg_d;
  scale_load_t load;

  // front to queue
  logic  push;
  step_t push_data;
  logic  q_full;

  // queue to back
  logic  q_valid;
  logic  q_pop;
  step_t q_data;

  // back result fields
  logic               res_ovf;
  logic [SCALE_W-1:0] res_scale;
  logic [CNT_W-1:0]   res_cnt;

  // register decode, unknown indexes fall through
  always_comb begin
    cfg_d        = cfg_q;
    load.load    = 1'b0;
    load.value   = cfg_data_i;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_SCALE: load.load      = 1'b1;
        CFG_BACKOFF:     cfg_d.backoff  = cfg_data_i[FACT_W-1:0];
        CFG_GROWTH:      cfg_d.growth   = cfg_data_i[FACT_W-1:0];
        CFG_INTERVAL:    cfg_d.interval = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backoff  <= BACKOFF_RESET;
      cfg_q.growth   <= GROWTH_RESET;
      cfg_q.interval <= INTERVAL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify words, keep the sticky flag, hand over each finished step
  dlsu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .q_full_i        (q_full)
  );

  // short queue so the word stream keeps flowing while the divider works
  dlsu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // back: scale and step count update, result register
  dlsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .load_i      (load),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_ovf_o   (res_ovf),
    .out_scale_o (res_scale),
    .out_cnt_o   (res_cnt)
  );

  assign m_axis_tdata_o = {res_cnt, res_scale};
  assign m_axis_tuser_o = res_ovf;

  // reported scale never drops under 1.0
  `DLSU_ASSERT_SAME(a_scale_floor, m_axis_tvalid_o, res_scale >= SCALE_ONE, "scale below one")
  // an overflow step always restarts the count
  `DLSU_ASSERT_SAME(a_ovf_clears_cnt, m_axis_tvalid_o && res_ovf, res_cnt == '0,
                    "count kept after overflow")
  // a clean step leaves the count below the interval or cleared by growth
  `DLSU_ASSERT_SAME(a_cnt_below_interval, m_axis_tvalid_o && !res_ovf,
                    (res_cnt < cfg_q.interval) || (res_cnt == '0), "count past interval")
  // a last word taken into an empty queue is waiting there next cycle
  `DLSU_ASSERT_NEXT(a_step_queued, push && !q_valid, q_valid, "finished step lost")

endmodule

// ===== rtl/dlsu_front.sv =====
// ----------------------------------------------------------------------------
// dlsu_front
// takes gradient words, flags inf/nan and queues one entry per step
// ----------------------------------------------------------------------------
module dlsu_front
  import dlsu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [GRAD_W-1:0] s_axis_tdata_i,  // grad_bits
  input  logic              s_axis_tlast_i,  // last
  output logic              push_o,
  output step_t             push_data_o,
  input  logic              q_full_i
);

  logic ovf_q, ovf_d;
  logic accept;
  logic hit;

  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // exponent all ones: inf or nan
  assign hit             = &s_axis_tdata_i[EXP_MSB:EXP_LSB];

  always_comb begin
    ovf_d           = ovf_q;
    push_o          = 1'b0;
    push_data_o.ovf = ovf_q | hit;
    if (accept) begin
      if (s_axis_tlast_i) begin
        push_o = 1'b1;
        ovf_d  = 1'b0;
      end else begin
        ovf_d = ovf_q | hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
    end
  end

endmodule

// ===== rtl/dlsu_queue.sv =====
// ----------------------------------------------------------------------------
// dlsu_queue
// two-entry queue of finished steps between front and back
// ----------------------------------------------------------------------------
module dlsu_queue
  import dlsu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output step_t pop_data_o
);

  step_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dlsu_back.sv =====
// ----------------------------------------------------------------------------
// dlsu_back
// scale update: serial backoff divide, growth multiply or count, then result register
// ----------------------------------------------------------------------------
module dlsu_back
  import dlsu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  scale_load_t        load_i,
  input  logic               q_valid_i,
  input  step_t              q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_ovf_o,
  output logic [SCALE_W-1:0] out_scale_o,
  output logic [CNT_W-1:0]   out_cnt_o
);

  back_state_e state_q, state_d;
  logic [SCALE_W-1:0]   scale_q, scale_d;
  logic [CNT_W-1:0]     step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 ovf_q, ovf_d;
  logic [SCALE_W-1:0]   quo_q, quo_d;
  logic [FACT_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] idx_q, idx_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic                 out_ovf_q, out_ovf_d;
  logic [SCALE_W-1:0]   out_scale_q, out_scale_d;
  logic [CNT_W-1:0]     out_cnt_q, out_cnt_d;

  logic [FACT_W-1:0]  div_eff, mul_eff;
  logic [CNT_W-1:0]   cnt_inc;
  logic               grow;
  logic [FACT_W:0]    trial, trial_sub;
  logic               ge;
  logic [SCALE_W-1:0] quo_next;
  logic [SCALE_W-1:0] sat_val;

  // zero factors act as one
  assign div_eff   = (cfg_i.backoff == '0) ? FACT_W'(1) : cfg_i.backoff;
  assign mul_eff   = (cfg_i.growth == '0) ? FACT_W'(1) : cfg_i.growth;
  assign cnt_inc   = step_q + CNT_W'(step_q != CNT_MAX);
  assign grow      = (cnt_inc >= cfg_i.interval);
  assign trial     = {rem_q, quo_q[SCALE_W-1]};
  assign ge        = (trial >= {1'b0, div_eff});
  assign trial_sub = trial - {1'b0, div_eff};
  assign quo_next  = {quo_q[SCALE_W-2:0], ge};
  assign sat_val   = (prod_q > PROD_W'(SCALE_MAX)) ? SCALE_MAX : prod_q[SCALE_W-1:0];

  always_comb begin
    state_d     = state_q;
    scale_d     = scale_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    ovf_d       = ovf_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    out_ovf_d   = out_ovf_q;
    out_scale_d = out_scale_q;
    out_cnt_d   = out_cnt_q;
    q_pop_o     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          ovf_d   = q_data_i.ovf;
          if (q_data_i.ovf) begin
            step_d  = '0;
            quo_d   = scale_q;
            rem_d   = '0;
            idx_d   = '0;
            state_d = S_DIV;
          end else if (grow) begin
            step_d  = '0;
            state_d = S_MUL;
          end else begin
            step_d  = cnt_inc;
            state_d = S_DONE;
          end
        end
      end
      S_DIV: begin
        quo_d = quo_next;
        rem_d = ge ? trial_sub[FACT_W-1:0] : trial[FACT_W-1:0];
        idx_d = idx_q + DIV_CNT_W'(1);
        if (idx_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          scale_d = at_least_one(quo_next);
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(scale_q) * PROD_W'(mul_eff);
        state_d = S_SAT;
      end
      S_SAT: begin
        scale_d = sat_val;
        state_d = S_DONE;
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        out_ovf_d   = ovf_q;
        out_scale_d = scale_q;
        out_cnt_d   = step_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // start scale write: the user issues it only while idle; the block does not enforce that
    if (load_i.load) begin
      scale_d = at_least_one(load_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scale_q     <= SCALE_RESET;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scale_q     <= scale_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q       <= ovf_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    idx_q       <= idx_d;
    prod_q      <= prod_d;
    out_ovf_q   <= out_ovf_d;
    out_scale_q <= out_scale_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_scale_o = out_scale_q;
  assign out_cnt_o   = out_cnt_q;

endmodule

// ===== bench/dynamic_loss_scale_update_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dynamic_loss_scale_update_core_test
// streams fp32 gradient words through the loss scale updater, predicts each
// step's overflow flag, new scale and clean step count, and compares them
// with the per-step result stream under random idling on both sides
// ----------------------------------------------------------------------------
module dynamic_loss_scale_update_core_test;
  import dlsu_pkg::*;

  localparam int SETTLE_CYCLES  = 64;    // extra wait after a drain before register writes
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word, update or register write
  localparam int PHASE_WORDS    = 167;   // random words per configuration phase

  // one gradient word as the sender presents it
  typedef struct packed {
    logic [GRAD_W-1:0] bits;
    logic              tail;
  } grad_word_t;

  // what one finished step reports
  typedef struct packed {
    logic               ovf;
    logic [SCALE_W-1:0] scale;
    logic [CNT_W-1:0]   steps;
  } scale_update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     cfg_we_i = 1'b0;
  logic [IDX_W-1:0]         cfg_idx_i = '0;
  logic [SCALE_W-1:0]       cfg_data_i = '0;
  logic                     s_axis_tvalid_i = 1'b0;
  logic                     s_axis_tready_o;
  logic [GRAD_W-1:0]        s_axis_tdata_i = '0;   // [31:0] grad_bits
  logic                     s_axis_tlast_i = 1'b0; // last
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i = 1'b0;
  logic [SCALE_W+CNT_W-1:0] m_axis_tdata_o;        // [39:0] scale_after, [55:40] clean_steps
  logic                     m_axis_tuser_o;        // overflow

  dynamic_loss_scale_update_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // words waiting for the sender, step updates waiting for the result stream
  grad_word_t    grad_words_q[$];
  scale_update_t step_updates_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          word_taken = 1'b0;

  // mirror of the scaler: registers, then scale, step count and sticky flag
  logic [FACT_W-1:0]  mir_backoff  = BACKOFF_RESET;
  logic [FACT_W-1:0]  mir_growth   = GROWTH_RESET;
  logic [CNT_W-1:0]   mir_interval = INTERVAL_RESET;
  logic [SCALE_W-1:0] mir_scale    = SCALE_RESET;
  logic [CNT_W-1:0]   mir_count    = '0;
  logic               mir_flag     = 1'b0;

  function automatic bit roll_pct(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // register write as seen by the scaler; narrow registers keep their low bits
  function automatic void load_reg(cfg_idx_e idx, logic [SCALE_W-1:0] val);
    case (idx)
      CFG_START_SCALE: begin
        // below 1.0 loads as 1.0; count and flag are untouched
        mir_scale = (val < SCALE_ONE) ? SCALE_ONE : val;
      end
      CFG_BACKOFF:  mir_backoff  = val[FACT_W-1:0];
      CFG_GROWTH:   mir_growth   = val[FACT_W-1:0];
      CFG_INTERVAL: mir_interval = val[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // one accepted gradient word; a step's last word yields one update
  function automatic void advance_scaler(logic [GRAD_W-1:0] w, logic tail);
    logic [FACT_W-1:0]  div;
    logic [FACT_W-1:0]  mul;
    logic [SCALE_W-1:0] quot;
    logic [PROD_W-1:0]  prod;
    scale_update_t      upd;
    // inf or nan: exponent all ones, the last word included
    if (&w[EXP_MSB:EXP_LSB]) mir_flag = 1'b1;
    if (!tail) return;
    if (mir_flag) begin
      // backoff: zero divisor acts as one, result never below 1.0
      div       = (mir_backoff == '0) ? FACT_W'(1) : mir_backoff;
      quot      = mir_scale / div;
      mir_scale = (quot < SCALE_ONE) ? SCALE_ONE : quot;
      mir_count = '0;
    end else begin
      if (mir_count != CNT_MAX) mir_count = mir_count + 1'b1;
      // zero interval grows on every clean step
      if (mir_count >= mir_interval) begin
        mul       = (mir_growth == '0) ? FACT_W'(1) : mir_growth;
        prod      = PROD_W'(mir_scale) * PROD_W'(mul);
        mir_scale = (prod > PROD_W'(SCALE_MAX)) ? SCALE_MAX : prod[SCALE_W-1:0];
        mir_count = '0;
      end
    end
    upd.ovf   = mir_flag;
    upd.scale = mir_scale;
    upd.steps = mir_count;
    step_updates_q.push_back(upd);
    mir_flag = 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void push_word(logic [GRAD_W-1:0] w, logic tail);
    grad_word_t gw;
    gw.bits = w;
    gw.tail = tail;
    grad_words_q.push_back(gw);
  endfunction

  // one step of random length; about a third of the steps carry inf or nan
  function automatic int queue_random_step();
    int unsigned len;
    int unsigned bad_pos;
    int unsigned r;
    bit          ovf;
    logic [GRAD_W-1:0] w;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(1, 4);
    else if (r < 95) len = $urandom_range(5, 16);
    else len = $urandom_range(17, 48);
    ovf     = roll_pct(30);
    bad_pos = $urandom_range(len - 1);
    for (int unsigned i = 0; i < len; i++) begin
      w = $urandom;
      // finite by default: knock one exponent bit down
      if (&w[EXP_MSB:EXP_LSB]) w[EXP_LSB + $urandom_range(7)] = 1'b0;
      if (ovf && (i == bad_pos || roll_pct(10))) begin
        w[EXP_MSB:EXP_LSB] = '1;
        if ($urandom_range(3) == 0) w[EXP_LSB-1:0] = '0;  // inf rather than nan
      end
      push_word(w, i == len - 1);
    end
    return len;
  endfunction

  // register write through the port, only while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [SCALE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    load_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for every word to go in and every update to come out, then wait
  // SETTLE_CYCLES more before the next register write
  task automatic drain_stream();
    while (grad_words_q.size() != 0 || s_axis_tvalid_i || step_updates_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_settings();
    logic [SCALE_W-1:0] val;
    if (roll_pct(75)) begin
      case ($urandom_range(5))
        0:       val = SCALE_W'($urandom_range(255));   // below 1.0
        1:       val = SCALE_ONE;
        2:       val = SCALE_MAX;
        default: val = {8'($urandom), 32'($urandom)};
      endcase
      write_reg(CFG_START_SCALE, val);
    end
    // narrow registers get junk above their width
    if (roll_pct(75)) begin
      val = {32'($urandom), 8'($urandom_range(1, 255))};
      case ($urandom_range(4))
        0: val[FACT_W-1:0] = '0;
        1: val[FACT_W-1:0] = 8'd1;
        2: val[FACT_W-1:0] = 8'd255;
        default: ;
      endcase
      write_reg(CFG_BACKOFF, val);
    end
    if (roll_pct(75)) begin
      val = {32'($urandom), 8'($urandom_range(1, 255))};
      case ($urandom_range(4))
        0: val[FACT_W-1:0] = '0;
        1: val[FACT_W-1:0] = 8'd1;
        2: val[FACT_W-1:0] = 8'd255;
        default: ;
      endcase
      write_reg(CFG_GROWTH, val);
    end
    if (roll_pct(75)) begin
      // mostly short intervals so growth shows up often
      val = {24'($urandom), 16'($urandom_range(1, 6))};
      case ($urandom_range(7))
        0: val[CNT_W-1:0] = '0;
        1: val[CNT_W-1:0] = CNT_MAX;
        2: val[CNT_W-1:0] = INTERVAL_RESET;
        default: ;
      endcase
      write_reg(CFG_INTERVAL, val);
    end
  endtask

  // input side: note whether a word went in and feed the mirror
  always @(posedge clk_i) begin
    word_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (word_taken) begin
      advance_scaler(s_axis_tdata_i, s_axis_tlast_i);
    end
  end

  // driver: present the next word or idle, change inputs on the falling edge
  always @(negedge clk_i) begin
    if (word_taken || !s_axis_tvalid_i) begin
      if (grad_words_q.size() != 0 && !roll_pct(src_idle_pct)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= grad_words_q[0].bits;
        s_axis_tlast_i  <= grad_words_q[0].tail;
        void'(grad_words_q.pop_front());
      end else begin
        // idle: data lines carry noise
        s_axis_tvalid_i <= 1'b0;
        s_axis_tdata_i  <= $urandom;
        s_axis_tlast_i  <= 1'($urandom_range(1));
      end
    end
    m_axis_tready_i <= rst_ni && !roll_pct(snk_idle_pct);
  end

  // monitor: compare each accepted update with the oldest prediction
  always @(posedge clk_i) begin
    scale_update_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (step_updates_q.size() == 0) begin
        report_mismatch("update with no step pending", 64'(m_axis_tdata_o), '0);
      end else begin
        want = step_updates_q.pop_front();
        if (m_axis_tuser_o !== want.ovf)
          report_mismatch("overflow", 64'(m_axis_tuser_o), 64'(want.ovf));
        if (m_axis_tdata_o[SCALE_W-1:0] !== want.scale)
          report_mismatch("scale_after", 64'(m_axis_tdata_o[SCALE_W-1:0]),
                          64'(want.scale));
        if (m_axis_tdata_o[SCALE_W+CNT_W-1:SCALE_W] !== want.steps)
          report_mismatch("clean_steps", 64'(m_axis_tdata_o[SCALE_W+CNT_W-1:SCALE_W]),
                          64'(want.steps));
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dynamic_loss_scale_update_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int words;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender idles lightly, receiver stalls heavily
    src_idle_pct = 28;
    snk_idle_pct = 88;

    // reset settings: finite extremes, nan and inf on the last word and before it
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h7F7F_FFFF, 1'b1);   // largest finite, clean step
    push_word(32'hFFFF_FFFF, 1'b1);   // nan on the last word itself
    push_word(32'h7F80_0000, 1'b0);   // +inf mid step
    push_word(32'h3F80_0000, 1'b1);
    push_word(32'h8000_0000, 1'b1);   // -0, clean
    push_word(32'hFF80_0000, 1'b0);   // -inf
    push_word(32'h7FC0_0000, 1'b0);   // quiet nan
    push_word(32'h0000_0001, 1'b1);
    push_word(32'h7F80_0001, 1'b1);   // signaling nan
    drain_stream();

    // zero registers: start scale below 1.0, divisor and multiplier act as one,
    // every clean step grows
    write_reg(CFG_START_SCALE, '0);
    write_reg(CFG_BACKOFF, '0);
    write_reg(CFG_GROWTH, '0);
    write_reg(CFG_INTERVAL, '0);
    push_word(32'h1234_5678, 1'b1);
    push_word(32'hFF80_0000, 1'b1);
    drain_stream();

    // maximum scale and factors: growth saturates, then full backoff
    write_reg(CFG_START_SCALE, SCALE_MAX);
    write_reg(CFG_BACKOFF, SCALE_W'(255));
    write_reg(CFG_GROWTH, SCALE_W'(255));
    write_reg(CFG_INTERVAL, SCALE_W'(1));
    push_word(32'h0000_0000, 1'b1);
    push_word(32'h7F80_0000, 1'b1);
    drain_stream();

    // backoff below 1.0 clamps
    write_reg(CFG_START_SCALE, SCALE_W'(300));
    push_word(32'hFFC0_0001, 1'b1);
    drain_stream();

    // longest interval, count just keeps going
    write_reg(CFG_START_SCALE, SCALE_W'(200));
    write_reg(CFG_GROWTH, SCALE_W'(1));
    write_reg(CFG_INTERVAL, SCALE_W'(CNT_MAX));
    push_word(32'h4049_0FDB, 1'b1);
    push_word(32'hC2F6_E979, 1'b1);
    drain_stream();

    // random phases, each under its own settings
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        src_idle_pct = 88;
        snk_idle_pct = 28;
      end else if (p == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      pick_settings();
      words = 0;
      while (words < PHASE_WORDS) words += queue_random_step();
      drain_stream();
    end

    if (mismatches == 0) begin
      $display("dynamic_loss_scale_update_core: match");
    end else begin
      $display("dynamic_loss_scale_update_core: mismatch");
    end
    $finish;
  end

endmodule
